>>> rtl/bs4b_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs4b_pkg: shared types and constants of the 4-byte bit-shuffle block
// Register indexes, field widths, block geometry and the sequencer states.
// ----------------------------------------------------------------------------
package bs4b_pkg;

  // Default block capacity in bytes (64 up to 512, whole 64-byte groups).
  localparam int DEF_MAX_BLOCK_BYTES = 512;

  // Word and field widths of the ports.
  localparam int WORD_W     = 64;
  localparam int GC_W       = 4;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_GROUP_COUNT  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_REVERSE_MODE = 1'b1;

  // Reset values of the registers.
  localparam logic [GC_W-1:0] GROUP_COUNT_RESET = 4'd8;

  // One group is 16 elements of 32 bits: 8 words, or 32 rows of 16 bits.
  localparam int ELEMS_PER_GROUP = 16;
  localparam int ELEM_BITS       = 32;
  localparam int LANES           = 4;
  localparam logic [4:0] ROW_LAST  = 5'd31;
  localparam logic [4:0] PAIR_LAST = 5'd7;

  // A stored word seen as four 16-bit row pieces.
  typedef logic [LANES-1:0][ELEMS_PER_GROUP-1:0] word_lanes_t;

  // The staging tile: element i, bit r.
  typedef logic [ELEMS_PER_GROUP-1:0][ELEM_BITS-1:0] tile_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_LOAD,
    ST_DRAIN,
    ST_SCATTER,
    ST_EMIT
  } seq_state_t;

endpackage

>>> rtl/bitshuffle_4byte_block_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitshuffle_4byte_block_top: bit transposition of buffered 4-byte elements
// The block collects a whole block of G*8 words of 64 bits (G groups of 64
// bytes, G taken from the group count register and held between 1 and the
// capacity), then sends out the same number of words with the bits
// transposed: in forward mode bit t of byte b of element e goes to bit
// (b*8+t)*N+e of the output, N = 16*G elements, and the reverse mode undoes
// that map. The mode is read while a block is transposed, so it may change
// between words, while a write of the group count drops any partial block.
// For one block of W = 8*G words the design takes the words in at one per
// cycle, then transposes each group in turn (one read pass over the block
// store into a 16x32 staging tile, a settle state for the last read, and
// one write pass from the tile into the shuffled store, 8 and 32 steps in
// either order), then sends the result at one word per cycle when the sink
// does not stall. The 32-step row pass of each group moves one 16-bit row
// piece per cycle: through the write port of the shuffled store in forward
// mode and through the read port of the block store in reverse mode. No
// input word is taken between the last word of a block and the issue of its
// last result word; the last result word may still wait at the output while
// the next block comes in. The stores need no clearing after reset.
// ----------------------------------------------------------------------------
module bitshuffle_4byte_block_top #(
  parameter int MAX_BLOCK_BYTES = bs4b_pkg::DEF_MAX_BLOCK_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [bs4b_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bs4b_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bs4b_pkg::WORD_W-1:0]     in_tdata,   // [63:0] in_word
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bs4b_pkg::WORD_W-1:0]     out_tdata,  // [63:0] out_word
  output logic                            out_tlast   // block_end
);

  import bs4b_pkg::*;

  localparam int STORE_WORDS = MAX_BLOCK_BYTES / 8;
  localparam int MAX_GROUPS  = MAX_BLOCK_BYTES / 64;
  localparam int WAW         = $clog2(STORE_WORDS);
  localparam int CW          = WAW + 2;
  localparam int GIW         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  // Configuration registers.
  logic [GC_W-1:0] group_count_r;
  logic            reverse_r;

  // Sequencer state and counters.
  seq_state_t      state_r, state_nxt;
  logic [WAW-1:0]  wr_cnt_r, wr_cnt_nxt;
  logic [GIW-1:0]  grp_r, grp_nxt;
  logic [4:0]      step_r, step_nxt;
  logic [CW-1:0]   chunk_r, chunk_nxt;
  logic [WAW-1:0]  em_r, em_nxt;

  // Returning block store reads.
  logic            ld_vld_r;
  logic [4:0]      ld_idx_r;
  logic [1:0]      ld_lane_r;

  // Stores, tile and output register.
  logic [WORD_W-1:0] block_store_r [STORE_WORDS];
  word_lanes_t       shuf_store_r  [STORE_WORDS];
  logic [WORD_W-1:0] raw_q_r;
  tile_t             tile_r;
  logic [WORD_W-1:0] out_q_r;
  logic              out_last_r;
  logic              out_valid_r;

  // Control strobes.
  logic            in_acc;
  logic            raw_rd_en;
  logic            shuf_wr_en;
  logic            rd_go;
  logic            cfg_gc_wr;

  // Derived values.
  logic [GC_W-1:0] geff;
  logic [WAW-1:0]  wlast;
  logic            grp_last;
  logic [4:0]      load_lim;
  logic [4:0]      scat_lim;
  logic [WAW-1:0]  addr_grp;
  logic [WAW-1:0]  addr_chk;
  logic [WAW-1:0]  raw_rd_addr;
  logic [WAW-1:0]  shuf_wr_addr;
  logic [LANES-1:0] shuf_lane_en;
  word_lanes_t     shuf_wr_data;
  logic [ELEMS_PER_GROUP-1:0] tile_row;
  logic [WORD_W-1:0] tile_pair;
  word_lanes_t     raw_lanes;
  logic [ELEMS_PER_GROUP-1:0] ld_piece;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  assign cfg_gc_wr = cfg_wr_en && (cfg_addr == REG_GROUP_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_count_r <= GROUP_COUNT_RESET;
      reverse_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_GROUP_COUNT:  group_count_r <= cfg_wdata[GC_W-1:0];
        REG_REVERSE_MODE: reverse_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A group count of zero acts as one; counts above the capacity saturate.
  always_comb begin
    if (group_count_r == '0) begin
      geff = GC_W'(1);
    end else if (group_count_r > GC_W'(MAX_GROUPS)) begin
      geff = GC_W'(MAX_GROUPS);
    end else begin
      geff = group_count_r;
    end
  end

  assign wlast    = WAW'({geff, 3'b000} - (GC_W + 3)'(1));
  assign grp_last = (grp_r == GIW'(geff - GC_W'(1)));

  // Forward mode reads 8 element pairs and writes 32 rows; reverse swaps.
  assign load_lim = reverse_r ? ROW_LAST : PAIR_LAST;
  assign scat_lim = reverse_r ? PAIR_LAST : ROW_LAST;

  // Word address inside the current group, and word address of a row piece.
  assign addr_grp = WAW'({grp_r, step_r[2:0]});
  assign addr_chk = chunk_r[CW-1:2];

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_acc && (wr_cnt_r == wlast)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (step_r == load_lim) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SCATTER;
      end
      ST_SCATTER: begin
        if (step_r == scat_lim) begin
          state_nxt = grp_last ? ST_EMIT : ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (rd_go && (em_r == wlast)) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    raw_rd_en  = 1'b0;
    shuf_wr_en = 1'b0;
    rd_go      = 1'b0;
    unique case (state_r)
      ST_COLLECT: in_tready  = 1'b1;
      ST_LOAD:    raw_rd_en  = 1'b1;
      ST_DRAIN:   ;
      ST_SCATTER: shuf_wr_en = 1'b1;
      ST_EMIT:    rd_go      = !out_valid_r || out_tready;
      default:    ;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  // Counter updates. The row piece index chunk_r runs as r*G + g.
  always_comb begin
    wr_cnt_nxt = wr_cnt_r;
    grp_nxt    = grp_r;
    step_nxt   = step_r;
    chunk_nxt  = chunk_r;
    em_nxt     = em_r;

    if (cfg_gc_wr) begin
      wr_cnt_nxt = '0;
    end else if (in_acc) begin
      wr_cnt_nxt = (wr_cnt_r == wlast) ? '0 : wr_cnt_r + WAW'(1);
    end

    case (state_r)
      ST_COLLECT: begin
        grp_nxt   = '0;
        step_nxt  = '0;
        chunk_nxt = '0;
        em_nxt    = '0;
      end
      ST_LOAD: begin
        if (step_r == load_lim) begin
          step_nxt  = '0;
          chunk_nxt = CW'(grp_r);
        end else begin
          step_nxt  = step_r + 5'd1;
          chunk_nxt = chunk_r + CW'(geff);
        end
      end
      ST_SCATTER: begin
        if (step_r == scat_lim) begin
          step_nxt  = '0;
          grp_nxt   = grp_last ? '0 : grp_r + GIW'(1);
          chunk_nxt = grp_last ? '0 : CW'(grp_r + GIW'(1));
        end else begin
          step_nxt  = step_r + 5'd1;
          chunk_nxt = chunk_r + CW'(geff);
        end
      end
      ST_EMIT: begin
        if (rd_go) begin
          em_nxt = (em_r == wlast) ? '0 : em_r + WAW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_COLLECT;
      wr_cnt_r  <= '0;
      grp_r     <= '0;
      step_r    <= '0;
      chunk_r   <= '0;
      em_r      <= '0;
      ld_vld_r  <= 1'b0;
      ld_idx_r  <= '0;
      ld_lane_r <= '0;
    end else begin
      state_r   <= state_nxt;
      wr_cnt_r  <= wr_cnt_nxt;
      grp_r     <= grp_nxt;
      step_r    <= step_nxt;
      chunk_r   <= chunk_nxt;
      em_r      <= em_nxt;
      ld_vld_r  <= raw_rd_en;
      ld_idx_r  <= step_r;
      ld_lane_r <= chunk_r[1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Block store: raw input words, one write and one read port.
  // Forward mode reads the 8 words of the group; reverse mode reads the
  // word that holds row piece r*G + g for each row r.
  // ---------------------------------------------------------------------
  assign raw_rd_addr = reverse_r ? addr_chk : addr_grp;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      block_store_r[wr_cnt_r] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_rd_en) begin
      raw_q_r <= block_store_r[raw_rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Staging tile: 16 elements of 32 bits. Forward mode fills it by
  // element pairs, reverse mode by rows of 16 bits.
  // ---------------------------------------------------------------------
  assign raw_lanes = raw_q_r;
  assign ld_piece  = raw_lanes[ld_lane_r];

  always_ff @(posedge clk) begin
    if (ld_vld_r) begin
      if (reverse_r) begin
        for (int i = 0; i < ELEMS_PER_GROUP; i++) begin
          tile_r[i][ld_idx_r] <= ld_piece[i];
        end
      end else begin
        tile_r[{ld_idx_r[2:0], 1'b0}] <= raw_q_r[ELEM_BITS-1:0];
        tile_r[{ld_idx_r[2:0], 1'b1}] <= raw_q_r[WORD_W-1:ELEM_BITS];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ELEMS_PER_GROUP; i++) begin
      tile_row[i] = tile_r[i][step_r];
    end
  end

  assign tile_pair = {tile_r[{step_r[2:0], 1'b1}], tile_r[{step_r[2:0], 1'b0}]};

  // ---------------------------------------------------------------------
  // Shuffled store: four 16-bit lanes per word. Forward mode writes one
  // row piece into its lane, reverse mode writes whole element pairs.
  // ---------------------------------------------------------------------
  always_comb begin
    if (reverse_r) begin
      shuf_wr_addr = addr_grp;
      shuf_lane_en = '1;
      shuf_wr_data = tile_pair;
    end else begin
      shuf_wr_addr = addr_chk;
      shuf_lane_en = LANES'(1) << chunk_r[1:0];
      shuf_wr_data = {LANES{tile_row}};
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (shuf_wr_en && shuf_lane_en[l]) begin
        shuf_store_r[shuf_wr_addr][l] <= shuf_wr_data[l];
      end
    end
  end

  // The read data register of the shuffled store is the output register.
  always_ff @(posedge clk) begin
    if (rd_go) begin
      out_q_r    <= shuf_store_r[em_r];
      out_last_r <= (em_r == wlast);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_q_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // A stalled result word stays on the bus unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // Reading the final word of a block returns the sequencer to collecting.
  a_end_leaves_emit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_go && (em_r == wlast) |=> state_r == ST_COLLECT)
    else $error("output phase still running after the final word");

  // The group index stays inside the block while it is transposed.
  a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_COLLECT |-> grp_r <= GIW'(geff - GC_W'(1)))
    else $error("group index beyond the block");
`endif

endmodule

>>> test/tb_bitshuffle_4byte_block_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitshuffle_4byte_block_top: self-checking bench for the 4-byte bit shuffle
// A short table of directed words and register writes runs first: saturating
// group counts, partial blocks dropped by a group count write, a mode change
// in the middle of a block, and all-ones and all-zeros blocks. Random phases
// with random block sizes, modes and words follow. Every output word is
// compared with a bit-level transpose model held in the bench, while the
// source sends in bursts and the sink stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_bitshuffle_4byte_block_top;
  import bs4b_pkg::*;

  // Geometry for the default block capacity.
  localparam int STORE_WORDS  = DEF_MAX_BLOCK_BYTES / 8;
  localparam int MAX_GROUPS   = DEF_MAX_BLOCK_BYTES / 64;
  localparam int ROWS         = 32;
  // Idle cycles before a register write and at the end of the run. Once the
  // last word of a block has left, the block is back to collecting.
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 64;
  localparam int RANDOM_WORDS  = 240;

  // One expected output word.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } shuffled_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // One row of the directed table: a word to send, or a register write.
  // Where typed is set, every word of the block that the row completes must
  // equal typed_word.
  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    logic [WORD_W-1:0]     word;
    bit                    typed;
    logic [WORD_W-1:0]     typed_word;
  } stim_row_t;

  // How the sink paces out_tready.
  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BURSTY} sink_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata;   // [63:0] in_word
  logic                  out_tvalid;
  logic                  out_tready;
  logic [WORD_W-1:0]     out_tdata;  // [63:0] out_word
  logic                  out_tlast;  // block_end

  bitshuffle_4byte_block_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bench copy of the block: the held words, the fill level and registers.
  logic [WORD_W-1:0] block_copy [STORE_WORDS];
  int unsigned       fill_count;
  logic [GC_W-1:0]   group_count_reg;
  logic              reverse_reg;

  shuffled_t   shuffled_q [$];
  stim_row_t   dir_rows [$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  int unsigned random_words;

  // The group count saturates into 1..MAX_GROUPS.
  function automatic int unsigned groups_of(input logic [GC_W-1:0] gc);
    if (gc < 1) begin
      return 1;
    end
    if (gc > MAX_GROUPS) begin
      return MAX_GROUPS;
    end
    return gc;
  endfunction

  function automatic stim_row_t word_row(input logic [WORD_W-1:0] w, input bit typed,
                                         input logic [WORD_W-1:0] tw);
    stim_row_t r;
    r.kind       = ROW_WORD;
    r.addr       = REG_GROUP_COUNT;
    r.data       = '0;
    r.word       = w;
    r.typed      = typed;
    r.typed_word = tw;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_ADDR_W-1:0] a,
                                        input logic [CFG_DATA_W-1:0] d);
    stim_row_t r;
    r.kind       = ROW_CFG;
    r.addr       = a;
    r.data       = d;
    r.word       = '0;
    r.typed      = 1'b0;
    r.typed_word = '0;
    return r;
  endfunction

  // Mostly dense random words, with some all-ones, all-zeros and sparse ones.
  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = '1;
      1:       w = '0;
      2:       w = 64'h1 << $urandom_range(0, 63);
      3:       w = {$urandom, $urandom} & {$urandom, $urandom};
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Mostly small blocks, a few mid-size ones and now and then the largest,
  // including counts of zero and above capacity that saturate.
  function automatic logic [GC_W-1:0] pick_group_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      return GC_W'($urandom_range(MAX_GROUPS, 15));
    end
    if (pick < 25) begin
      return GC_W'($urandom_range(4, MAX_GROUPS - 1));
    end
    return GC_W'($urandom_range(0, 3));
  endfunction

  // Takes one accepted word into the bench copy. When it completes a block,
  // the transposed block is queued as expected output words.
  task automatic absorb_word(input logic [WORD_W-1:0] w, input bit typed,
                             input logic [WORD_W-1:0] tw);
    int unsigned words;
    int unsigned elems;
    int unsigned p;
    int unsigned src;
    logic [WORD_W-1:0] acc;
    words = groups_of(group_count_reg) * 8;
    elems = groups_of(group_count_reg) * ELEMS_PER_GROUP;
    block_copy[fill_count] = w;
    fill_count++;
    if (fill_count < words) begin
      return;
    end
    fill_count = 0;
    for (int unsigned wi = 0; wi < words; wi++) begin
      acc = '0;
      for (int unsigned k = 0; k < WORD_W; k++) begin
        p = wi * WORD_W + k;
        if (!reverse_reg) begin
          // Output bit p is bit row p / N of element p % N.
          src = (p % elems) * ROWS + p / elems;
        end else begin
          // Inverse: output bit p is element p / 32, bit p % 32.
          src = (p % ROWS) * elems + p / ROWS;
        end
        acc[k] = block_copy[src / WORD_W][src % WORD_W];
      end
      shuffled_q.push_back('{word: typed ? tw : acc, last: (wi + 1 == words)});
    end
  endtask

  // Sends one word. Called at a falling edge, returns at a falling edge with
  // in_tvalid still high, so back-to-back words keep the valid asserted.
  task automatic put_word(input logic [WORD_W-1:0] w, input bit typed,
                          input logic [WORD_W-1:0] tw);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    absorb_word(w, typed, tw);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) begin
      put_word(rand_word(), 1'b0, '0);
      random_words++;
    end
  endtask

  // Drops the source valid and waits until every expected word has left and
  // the block has had time to settle. Called at a falling edge.
  task automatic drain_out();
    in_tvalid <= 1'b0;
    while (shuffled_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write on an idle block; the bench copy follows the same rules.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    drain_out();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (a == REG_GROUP_COUNT) begin
      // A group count write drops any partial block.
      group_count_reg = d[GC_W-1:0];
      fill_count      = 0;
    end else if (a == REG_REVERSE_MODE) begin
      reverse_reg = d[0];
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sink: out_tready follows a pattern that is picked again and again at random,
  // from always ready through coin flips to long stalls.
  initial begin
    sink_mode_t  mode;
    int unsigned span;
    int unsigned tick;
    tick       = 0;
    out_tready = 1'b0;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(30, 200);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          SINK_OPEN:   out_tready <= 1'b1;
          SINK_COIN:   out_tready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_tready <= (tick % 4 == 0);
          default:     out_tready <= ($urandom_range(0, 15) == 0) ? ~out_tready : out_tready;
        endcase
      end
    end
  end

  // Output checker: each word taken from the block against the oldest
  // expectation.
  always @(posedge clk) begin
    shuffled_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (shuffled_q.size() == 0) begin
        report_mismatch($sformatf("word %h with none expected", out_tdata));
      end else begin
        want = shuffled_q.pop_front();
        if (out_tdata !== want.word) begin
          report_mismatch($sformatf("out_word %h, expected %h", out_tdata, want.word));
        end
        if (out_tlast !== want.last) begin
          report_mismatch($sformatf("block_end %b, expected %b", out_tlast, want.last));
        end
      end
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [GC_W-1:0] gc;
    int unsigned     words;
    int unsigned     blocks;
    int unsigned     split;
    int unsigned     phase;

    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_addr        = '0;
    cfg_wdata       = '0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    fill_count      = 0;
    group_count_reg = GROUP_COUNT_RESET;
    reverse_reg     = 1'b0;
    mismatch_count  = 0;
    burst_left      = 0;
    random_words    = 0;

    // Directed table. A partial block under the reset count of 8 groups is
    // dropped by a count of zero, which saturates to one group.
    dir_rows.push_back(word_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0));
    dir_rows.push_back(word_row(64'hA5A5_5A5A_0F0F_F0F0, 1'b0, '0));
    dir_rows.push_back(cfg_row(REG_GROUP_COUNT, 4'd0));
    // All ones transposes to all ones.
    repeat (8) dir_rows.push_back(word_row('1, 1'b1, '1));
    // Mode set to reverse, then back to forward in the middle of a block:
    // the mode at the time the block completes counts.
    dir_rows.push_back(cfg_row(REG_REVERSE_MODE, 4'd1));
    dir_rows.push_back(word_row(64'h0000_0000_0000_0001, 1'b0, '0));
    dir_rows.push_back(word_row(64'h8000_0000_0000_0000, 1'b0, '0));
    dir_rows.push_back(word_row(64'h0123_4567_89AB_CDEF, 1'b0, '0));
    dir_rows.push_back(cfg_row(REG_REVERSE_MODE, 4'd0));
    dir_rows.push_back(word_row(64'hFFFF_FFFF_0000_0000, 1'b0, '0));
    dir_rows.push_back(word_row(64'h0000_0000_FFFF_FFFF, 1'b0, '0));
    dir_rows.push_back(word_row(64'h5555_5555_5555_5555, 1'b0, '0));
    dir_rows.push_back(word_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0));
    dir_rows.push_back(word_row(64'hFEDC_BA98_7654_3210, 1'b0, '0));
    // All zeros in reverse mode with one group.
    dir_rows.push_back(cfg_row(REG_REVERSE_MODE, 4'd1));
    dir_rows.push_back(cfg_row(REG_GROUP_COUNT, 4'd1));
    repeat (8) dir_rows.push_back(word_row('0, 1'b1, '0));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        put_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].typed_word);
      end
    end

    // Random phases. The first uses a count above capacity (saturates to the
    // full block); later ones mostly use small blocks. Some blocks get a
    // mode write in their middle, and some phases end in a partial block
    // that the next group count write throws away.
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      gc = (phase == 0) ? 4'd15 : pick_group_count();
      write_reg(REG_GROUP_COUNT, CFG_DATA_W'(gc));
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        write_reg(REG_REVERSE_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      end
      words  = groups_of(gc) * 8;
      blocks = (words >= 32) ? 1 : $urandom_range(1, 3);
      repeat (blocks) begin
        if ($urandom_range(0, 2) == 0) begin
          split = $urandom_range(1, words - 1);
          send_random(split);
          write_reg(REG_REVERSE_MODE, CFG_DATA_W'($urandom_range(0, 1)));
          send_random(words - split);
        end else begin
          send_random(words);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        send_random($urandom_range(1, words - 1));
      end
      phase++;
    end

    // Wait for the last block, then give stray words a chance to show.
    in_tvalid <= 1'b0;
    while (shuffled_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
